>>> hw/rtl/field_relative_x_drive_mixer_core_defines.svh
// assertion helpers for the x-drive mixer
`ifndef FIELD_RELATIVE_X_DRIVE_MIXER_CORE_DEFINES_SVH
`define FIELD_RELATIVE_X_DRIVE_MIXER_CORE_DEFINES_SVH

// checked only outside reset
`define FXDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define FXDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fxdm_pkg.sv
package fxdm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 33;
  localparam int PW           = 16 + CW;
  localparam int SW           = PW + 1;
  localparam int WW           = 20;
  localparam int MW           = WW - 1;
  localparam int LW           = 15;
  localparam int NW           = MW + LW;
  localparam int DIV_STEPS    = LW;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [LW-1:0]        LIMIT_RESET = 15'd25600;
  localparam logic [2:0]           ADDR_LIMIT  = 3'd0;

  typedef logic signed [WW-1:0] wheel_t;

  typedef struct packed {
    logic signed [15:0] f;
    logic signed [15:0] r;
    logic signed [15:0] t;
    logic               ok;
  } side_t;

  typedef struct packed {
    logic signed [15:0] fl;
    logic signed [15:0] fr;
    logic signed [15:0] bl;
    logic signed [15:0] br;
    logic               scaled;
  } result_t;

  function automatic logic signed [CW-1:0] atan_turn(input int unsigned idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 33'sh20000000;
      1:  v = 33'sh12E4051E;
      2:  v = 33'sh09FB385B;
      3:  v = 33'sh051111D4;
      4:  v = 33'sh028B0D43;
      5:  v = 33'sh0145D7E1;
      6:  v = 33'sh00A2F61E;
      7:  v = 33'sh00517C55;
      8:  v = 33'sh0028BE53;
      9:  v = 33'sh00145F2F;
      10: v = 33'sh000A2F98;
      11: v = 33'sh000517CC;
      12: v = 33'sh00028BE6;
      13: v = 33'sh000145F3;
      14: v = 33'sh0000A2FA;
      15: v = 33'sh0000517D;
      16: v = 33'sh000028BE;
      17: v = 33'sh0000145F;
      18: v = 33'sh00000A30;
      19: v = 33'sh00000518;
      20: v = 33'sh0000028C;
      21: v = 33'sh00000146;
      22: v = 33'sh000000A3;
      23: v = 33'sh00000051;
      24: v = 33'sh00000029;
      25: v = 33'sh00000014;
      26: v = 33'sh0000000A;
      27: v = 33'sh00000005;
      28: v = 33'sh00000003;
      29: v = 33'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/fxdm_cordic.sv
module fxdm_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  fxdm_pkg::side_t              in_side,
  input  logic [15:0]                  in_angle,
  output logic                         out_valid,
  output fxdm_pkg::side_t              out_side,
  output logic                         out_flip,
  output logic signed [fxdm_pkg::CW-1:0] out_x,
  output logic signed [fxdm_pkg::CW-1:0] out_y
);
  import fxdm_pkg::*;

  logic [31:0]          phase;
  logic [31:0]          phase_q;
  logic [31:0]          phase_fold;
  logic                 flip_in;

  logic                 vs [CORDIC_STEPS+1];
  side_t                ss [CORDIC_STEPS+1];
  logic                 fs [CORDIC_STEPS+1];
  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [CW-1:0] zs [CORDIC_STEPS+1];

  // fold the phase into the right half plane
  assign phase      = {in_angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
  assign phase_q    = phase + 32'h4000_0000;
  assign flip_in    = phase_q[31];
  assign phase_fold = flip_in ? phase - 32'h8000_0000 : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss[0] <= in_side;
      fs[0] <= flip_in;
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= CW'(signed'(phase_fold));
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ss[i+1] <= ss[i];
        fs[i+1] <= fs[i];
        if (!zs[i][CW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_turn(i);
        end
      end
    end
  end

  assign out_valid = vs[CORDIC_STEPS];
  assign out_side  = ss[CORDIC_STEPS];
  assign out_flip  = fs[CORDIC_STEPS];
  assign out_x     = xs[CORDIC_STEPS];
  assign out_y     = ys[CORDIC_STEPS];

endmodule

>>> hw/rtl/fxdm_mix.sv
module fxdm_mix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  fxdm_pkg::side_t                in_side,
  input  logic                           in_flip,
  input  logic signed [fxdm_pkg::CW-1:0] in_x,
  input  logic signed [fxdm_pkg::CW-1:0] in_y,
  output logic                           out_valid,
  output fxdm_pkg::wheel_t               out_w [4]
);
  import fxdm_pkg::*;

  localparam logic signed [SW-1:0] ROUND = SW'(64'sd536870912);

  logic signed [CW-1:0] cn;
  logic signed [CW-1:0] sn;

  logic                 va;
  side_t                sa;
  logic signed [PW-1:0] pfc;
  logic signed [PW-1:0] prs;
  logic signed [PW-1:0] prc;
  logic signed [PW-1:0] pfs;

  logic signed [SW-1:0] sum_fwd;
  logic signed [SW-1:0] sum_rgt;

  logic                 vb;
  logic signed [15:0]   tb;
  wheel_t               fwd;
  wheel_t               rgt;
  wheel_t               tw;

  logic                 vc;

  assign cn = in_flip ? -in_x : in_x;
  assign sn = in_flip ? -in_y : in_y;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa  <= in_side;
      pfc <= PW'(in_side.f) * PW'(cn);
      prs <= PW'(in_side.r) * PW'(sn);
      prc <= PW'(in_side.r) * PW'(cn);
      pfs <= PW'(in_side.f) * PW'(sn);
    end
  end

  // round to nearest, halves up
  assign sum_fwd = (SW'(pfc) + SW'(prs) + ROUND) >>> 30;
  assign sum_rgt = (SW'(prc) - SW'(pfs) + ROUND) >>> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      tb <= sa.t;
      if (sa.ok) begin
        fwd <= sum_fwd[WW-1:0];
        rgt <= sum_rgt[WW-1:0];
      end else begin
        fwd <= WW'(sa.f);
        rgt <= WW'(sa.r);
      end
    end
  end

  assign tw = WW'(tb);

  always_ff @(posedge clk) begin
    if (en) begin
      out_w[0] <= fwd + rgt + tw;
      out_w[1] <= fwd - rgt - tw;
      out_w[2] <= fwd - rgt + tw;
      out_w[3] <= fwd + rgt - tw;
    end
  end

  assign out_valid = vc;

endmodule

>>> hw/rtl/fxdm_norm.sv
module fxdm_norm (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [fxdm_pkg::LW-1:0]  limit,
  input  logic                     in_valid,
  input  fxdm_pkg::wheel_t         in_w [4],
  output logic                     out_valid,
  output fxdm_pkg::result_t        out_res
);
  import fxdm_pkg::*;

  logic [MW-1:0]  m [4];
  logic [MW-1:0]  pk01;
  logic [MW-1:0]  pk23;
  logic [MW-1:0]  pk;

  logic           vd [DIV_STEPS+1];
  logic           sc [DIV_STEPS+1];
  logic [MW-1:0]  pd [DIV_STEPS+1];
  wheel_t         wd [DIV_STEPS+1][4];
  logic [NW-1:0]  rem [DIV_STEPS+1][4];
  logic [DIV_STEPS-1:0] qd [DIV_STEPS+1][4];

  logic           vo;
  logic [15:0]    res [4];

  for (genvar k = 0; k < 4; k++) begin : g_mag
    assign m[k] = in_w[k][WW-1] ? MW'(-in_w[k]) : MW'(in_w[k]);
  end

  assign pk01 = (m[1] > m[0]) ? m[1] : m[0];
  assign pk23 = (m[3] > m[2]) ? m[3] : m[2];
  assign pk   = (pk23 > pk01) ? pk23 : pk01;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (en) begin
      vd[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc[0] <= pk > MW'(limit);
      pd[0] <= pk;
      for (int k = 0; k < 4; k++) begin
        wd[0][k]  <= in_w[k];
        rem[0][k] <= NW'(m[k]) * NW'(limit);
        qd[0][k]  <= '0;
      end
    end
  end

  // restoring division, one quotient bit a stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [NW-1:0] dsh;
    assign dsh = NW'(pd[j]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (en) begin
        vd[j+1] <= vd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sc[j+1] <= sc[j];
        pd[j+1] <= pd[j];
      end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
      logic ge;
      assign ge = rem[j][k] >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          wd[j+1][k]  <= wd[j][k];
          rem[j+1][k] <= ge ? rem[j][k] - dsh : rem[j][k];
          qd[j+1][k]  <= qd[j][k] | (ge ? DIV_STEPS'(1) << B : '0);
        end
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_sel
    logic [15:0] q16;
    assign q16 = 16'(qd[DIV_STEPS][k]);
    always_comb begin
      if (sc[DIV_STEPS]) begin
        res[k] = wd[DIV_STEPS][k][WW-1] ? -q16 : q16;
      end else begin
        res[k] = wd[DIV_STEPS][k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vd[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.fl     <= res[0];
      out_res.fr     <= res[1];
      out_res.bl     <= res[2];
      out_res.br     <= res[3];
      out_res.scaled <= sc[DIV_STEPS];
    end
  end

  assign out_valid = vo;

endmodule

>>> hw/rtl/field_relative_x_drive_mixer_core.sv
// field-relative x-drive wheel mixer
// input channel s_*: one drive command per transfer, heading_ok on s_tuser
// output channel m_*: four wheel commands per transfer, was_scaled on m_tuser
// apb port: output_limit at byte address 0, to be written while the block is idle (not enforced by the block)
// the path from input transfer to output valid runs through the sine/cosine
// cordic (fold plus one stage per step), rotate and mix, then peak search,
// the 15-stage divider and the output register
// throughput is one command per cycle while the output is not stalled, set by the fully pipelined path
// a stalled output freezes the whole pipeline, so nothing is lost or repeated,
// and s_tready follows m_tready while a result is waiting
// reset empties the pipeline and loads output_limit with 25600
module field_relative_x_drive_mixer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // field_forward, field_right, heading_angle, turn_request
  input  logic [63:0] s_tdata,
  // heading_ok
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // wheel_front_left, wheel_front_right, wheel_back_left, wheel_back_right
  output logic [63:0] m_tdata,
  // was_scaled
  output logic [0:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fxdm_pkg::*;

  `include "field_relative_x_drive_mixer_core_defines.svh"

  logic [LW-1:0]        output_limit;
  logic                 adv;
  side_t                side_in;

  logic                 c_valid;
  side_t                c_side;
  logic                 c_flip;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;

  logic                 w_valid;
  wheel_t               w_mix [4];

  logic                 o_valid;
  result_t              o_res;

  logic [15:0]          mag_fl;
  logic [15:0]          mag_br;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LIMIT) ? {{(32-LW){1'b0}}, output_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LIMIT) begin
      output_limit <= pwdata[LW-1:0];
    end
  end

  assign adv      = !o_valid || m_tready;
  assign s_tready = adv;

  assign side_in.f  = s_tdata[15:0];
  assign side_in.r  = s_tdata[31:16];
  assign side_in.t  = s_tdata[63:48];
  assign side_in.ok = s_tuser[0];

  fxdm_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .in_side   (side_in),
    .in_angle  (s_tdata[47:32]),
    .out_valid (c_valid),
    .out_side  (c_side),
    .out_flip  (c_flip),
    .out_x     (c_x),
    .out_y     (c_y)
  );

  fxdm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .in_side   (c_side),
    .in_flip   (c_flip),
    .in_x      (c_x),
    .in_y      (c_y),
    .out_valid (w_valid),
    .out_w     (w_mix)
  );

  fxdm_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .limit     (output_limit),
    .in_valid  (w_valid),
    .in_w      (w_mix),
    .out_valid (o_valid),
    .out_res   (o_res)
  );

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_res.br, o_res.bl, o_res.fr, o_res.fl};
  assign m_tuser  = o_res.scaled;

  assign mag_fl = o_res.fl[15] ? -o_res.fl : o_res.fl;
  assign mag_br = o_res.br[15] ? -o_res.br : o_res.br;

  `FXDM_ASSERT(a_scaled_fl_in_limit, m_tvalid && m_tuser[0] |-> mag_fl <= 16'(output_limit), "scaled front left wheel above limit")
  `FXDM_ASSERT(a_scaled_br_in_limit, m_tvalid && m_tuser[0] |-> mag_br <= 16'(output_limit), "scaled back right wheel above limit")
  `FXDM_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_tvalid, "output valid right after reset")

endmodule

>>> test/tb_top.sv
module tb_top;
  import fxdm_pkg::*;

  localparam int LATENCY = 51;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] fwd;
    logic signed [15:0] rgt;
    logic [15:0]        hdg;
    logic               hdg_ok;
    logic signed [15:0] turn;
  } drive_cmd_t;

  typedef struct {
    logic signed [15:0] w [4];
    logic               scaled;
  } wheel_cmd_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  field_relative_x_drive_mixer_core dut (.*);

  drive_cmd_t pending_cmds[$];
  wheel_cmd_t expected_wheels[$];
  logic [14:0] limit_q;
  int send_idle_pct, recv_idle_pct;
  int errors;
  int quiet_cycles;
  bit hold_send;

  longint atan_tab [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  function automatic void heading_sin_cos(input logic [15:0] a,
                                          output longint c, output longint s);
    logic [31:0] p;
    bit flip;
    longint x, y, z, dx, dy;
    p = {a, 16'h0};
    flip = 0;
    x = 652032874;
    y = 0;
    if (((p + 32'h40000000) & 32'h80000000) != 0) begin
      p = p - 32'h80000000;
      flip = 1;
    end
    z = longint'($signed(p));
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic wheel_cmd_t mix_wheels(input drive_cmd_t d, input logic [14:0] lim);
    wheel_cmd_t res;
    longint f, r, t, fw, rg, c, s, peak, l;
    longint w [4];
    f = longint'(d.fwd); r = longint'(d.rgt); t = longint'(d.turn);
    fw = f; rg = r;
    if (d.hdg_ok) begin
      heading_sin_cos(d.hdg, c, s);
      fw = (f * c + r * s + (64'sd1 <<< 29)) >>> 30;
      rg = (r * c - f * s + (64'sd1 <<< 29)) >>> 30;
    end
    w[0] = fw + rg + t;
    w[1] = fw - rg - t;
    w[2] = fw - rg + t;
    w[3] = fw + rg - t;
    peak = 0;
    foreach (w[k]) if ((w[k] < 0 ? -w[k] : w[k]) > peak) peak = w[k] < 0 ? -w[k] : w[k];
    l = longint'(lim);
    res.scaled = peak > l;
    foreach (w[k]) begin
      if (res.scaled) w[k] = (w[k] * l) / peak;
      res.w[k] = w[k][15:0];
    end
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_cmds.size() != 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        drive_cmd_t d;
        d = pending_cmds.pop_front();
        s_tvalid <= 1;
        s_tdata <= {d.turn, d.hdg, d.rgt, d.fwd};
        s_tuser <= d.hdg_ok;
        expected_wheels.push_back(mix_wheels(d, limit_q));
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      quiet_cycles <= 0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_idle_pct;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (expected_wheels.size() == 0) begin
          $display("%0t: unexpected result %h %b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          wheel_cmd_t e;
          e = expected_wheels.pop_front();
          for (int k = 0; k < 4; k++)
            if (m_tdata[16*k +: 16] !== e.w[k]) begin
              $display("%0t: wheel %0d expected %0d actual %0d", $time, k, e.w[k],
                       $signed(m_tdata[16*k +: 16]));
              errors++;
            end
          if (m_tuser[0] !== e.scaled) begin
            $display("%0t: was_scaled expected %b actual %b", $time, e.scaled, m_tuser[0]);
            errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [14:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_LIMIT; pwdata <= {17'h0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    limit_q = v;
  endtask

  task automatic drain;
    while (pending_cmds.size() != 0 || expected_wheels.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic push_cmd(input int f, input int r, input int h, input bit ok, input int t);
    drive_cmd_t d;
    d.fwd = 16'(f); d.rgt = 16'(r); d.hdg = 16'(h); d.hdg_ok = ok; d.turn = 16'(t);
    pending_cmds.push_back(d);
  endtask

  function automatic int rand_pct();
    case ($urandom_range(5))
      0: return 25600;
      1: return -25600;
      2: return $urandom_range(65535) - 32768;
      default: return $signed(16'($urandom_range(51200))) - 25600;
    endcase
  endfunction

  task automatic add_random(input int n);
    repeat (n) push_cmd(rand_pct(), rand_pct(), $urandom_range(65535),
                        1'($urandom_range(1)), rand_pct());
  endtask

  initial begin
    errors = 0;
    hold_send = 0;
    send_idle_pct = 21;
    recv_idle_pct = 64;
    limit_q = LIMIT_RESET;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;

    push_cmd(0, 0, 0, 0, 0);
    push_cmd(25600, 0, 0, 0, 0);
    push_cmd(-25600, 25600, 0, 0, 25600);
    push_cmd(25600, 25600, 0, 1, -25600);
    push_cmd(25600, 0, 16384, 1, 0);
    push_cmd(25600, 0, 32768, 1, 0);
    push_cmd(25600, 0, 49152, 1, 0);
    push_cmd(0, 25600, 65535, 1, 0);
    push_cmd(-32768, -32768, 8192, 1, -32768);
    push_cmd(32767, 32767, 24576, 1, 32767);
    push_cmd(100, -100, 40960, 1, 50);
    push_cmd(0, 0, 12345, 1, 0);
    push_cmd(-1, 1, 57344, 1, -1);
    drain();

    hold_send = 1;
    add_random(200);
    repeat (20) @(posedge clk);
    hold_send = 0;
    drain();

    apb_write(15'd1);
    push_cmd(0, 0, 0, 0, 0);
    push_cmd(5, -3, 0, 0, 2);
    add_random(150);
    drain();

    apb_write(15'h7FFF);
    add_random(150);
    drain();

    apb_write(15'd0);
    push_cmd(0, 0, 0, 0, 0);
    push_cmd(1, 0, 0, 0, 0);
    add_random(100);
    drain();

    send_idle_pct = 64;
    recv_idle_pct = 21;
    apb_write(15'd12800);
    add_random(350);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(LIMIT_RESET);
    add_random(350);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
